// ----- rtl/two_class_priority_queue_macros.svh -----
// assertion macros shared by the queue rtl
`ifndef TWO_CLASS_PRIORITY_QUEUE_MACROS_SVH
`define TWO_CLASS_PRIORITY_QUEUE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define TCPQ_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// property whose consequent must hold in the cycle after the antecedent
`define TCPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tcpq_pkg.sv -----
`timescale 1ns / 1ps
package tcpq_pkg;

	// queue geometry
	localparam int DEPTH   = 16;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int ID_W    = 16;
	localparam int LEVEL_W = 8;
	localparam int CMD_W   = 2;
	localparam int OCC_W   = 5;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SERVE    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WITHDRAW = 2'd2;

	localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 8'd60;

	// one stored entry
	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            pref;
	} entry_t;

	// per-cell control from the queue controller
	typedef struct packed {
		logic occupied;
		logic load;
		logic shift_up;
		logic shift_down_all;
		logic withdraw;
	} cell_ctrl_t;

endpackage

// ----- rtl/tcpq_req_if.sv -----
`timescale 1ns / 1ps
interface tcpq_req_if;
	logic                          valid;
	logic                          ready;
	logic [tcpq_pkg::CMD_W-1:0]    command;
	logic [tcpq_pkg::ID_W-1:0]     entry_id;
	logic [tcpq_pkg::LEVEL_W-1:0]  level;

	modport source (output valid, output command, output entry_id, output level, input ready);
	modport sink (input valid, input command, input entry_id, input level, output ready);
endinterface

// ----- rtl/tcpq_rsp_if.sv -----
`timescale 1ns / 1ps
interface tcpq_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        ok;
	logic [tcpq_pkg::ID_W-1:0]   served_id;
	logic [tcpq_pkg::OCC_W-1:0]  occupancy;

	modport source (output valid, output ok, output served_id, output occupancy, input ready);
	modport sink (input valid, input ok, input served_id, input occupancy, output ready);
endinterface

// ----- rtl/tcpq_cell.sv -----
`timescale 1ns / 1ps
module tcpq_cell (
	input  logic                     clk,
	input  tcpq_pkg::cell_ctrl_t     ctrl,
	input  logic [tcpq_pkg::ID_W-1:0] key_id,
	input  tcpq_pkg::entry_t         new_entry,
	input  tcpq_pkg::entry_t         prev_entry,
	input  tcpq_pkg::entry_t         next_entry,
	input  logic                     hit_in,
	input  logic                     pref_hit_in,
	output tcpq_pkg::entry_t         entry,
	output logic                     hit_out,
	output logic                     pref_hit_out
);

	tcpq_pkg::entry_t entry_q;
	logic             match;
	logic             shift_down;

	// id compare and hit ripple toward the tail
	assign match        = ctrl.occupied && (entry_q.id == key_id);
	assign hit_out      = hit_in || match;
	assign pref_hit_out = pref_hit_in || (match && entry_q.pref);

	// a withdraw closes the gap from the matching slot onward
	assign shift_down = ctrl.shift_down_all || (ctrl.withdraw && hit_out);

	// slot update
	always_ff @(posedge clk) begin
		priority if (ctrl.load) begin
			entry_q <= new_entry;
		end else if (ctrl.shift_up) begin
			entry_q <= prev_entry;
		end else if (shift_down) begin
			entry_q <= next_entry;
		end else begin
			entry_q <= entry_q;
		end
	end

	assign entry = entry_q;

endmodule

// ----- rtl/two_class_priority_queue.sv -----
`timescale 1ns / 1ps
// Two-class queue of unique 16-bit ids held in a row of slot cells.
// Channel req carries command (insert, serve, withdraw), entry_id and level;
// channel rsp returns ok, served_id and the occupancy after the command.
// Both use valid/ready; a transaction moves when both are high.
// cfg_we/cfg_wdata write the priority threshold; an insert with level at
// or above it joins the end of the preferred class, else the normal class.
// All slots compare their ids with entry_id at once and shift together, so
// one command is accepted per cycle while rsp is not stalled, and the response
// appears in the output register in the cycle after acceptance.
// The rate is set by the compare-and-shift pass across the cell row.
// A full response register that is not taken stalls req; while rsp.ready
// is high the block keeps taking one command per cycle.
// Reset empties the queue at once (counts cleared, slot contents left as
// they are) and restores the threshold to 60; no clearing pass is needed.
module two_class_priority_queue (
	input  logic                                 clk,
	input  logic                                 arst_n,
	tcpq_req_if.sink                             req,
	tcpq_rsp_if.source                           rsp,
	input  logic                                 cfg_we,
	input  logic [tcpq_pkg::LEVEL_W-1:0]         cfg_wdata
);

	`include "two_class_priority_queue_macros.svh"

	localparam int DEPTH = tcpq_pkg::DEPTH;
	localparam int CNT_W = tcpq_pkg::CNT_W;

	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W-1:0]                  pcount_q;
	logic [CNT_W-1:0]                  count_d;
	logic [CNT_W-1:0]                  pcount_d;
	logic [tcpq_pkg::LEVEL_W-1:0]      thr_q;
	logic                              rsp_valid_q;
	logic                              ok_q;
	logic [tcpq_pkg::ID_W-1:0]         served_q;
	logic [tcpq_pkg::OCC_W-1:0]        occ_q;

	logic                              fire;
	logic                              is_insert;
	logic                              is_serve;
	logic                              is_withdraw;
	logic                              ins_pref;
	logic                              full;
	logic                              any_hit;
	logic                              ins_ok;
	logic                              serve_ok;
	logic                              withdraw_ok;
	logic                              ok_d;
	logic [tcpq_pkg::ID_W-1:0]         served_d;

	tcpq_pkg::entry_t                  new_entry;
	tcpq_pkg::entry_t                  slot [DEPTH];
	tcpq_pkg::cell_ctrl_t              ctrl [DEPTH];
	logic [DEPTH:0]                    hit_c;
	logic [DEPTH:0]                    pref_c;

	// handshake
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;

	// command decode
	assign is_insert   = req.command == tcpq_pkg::CMD_INSERT;
	assign is_serve    = req.command == tcpq_pkg::CMD_SERVE;
	assign is_withdraw = req.command == tcpq_pkg::CMD_WITHDRAW;
	assign ins_pref    = req.level >= thr_q;
	assign full        = count_q == CNT_W'(DEPTH);
	assign any_hit     = hit_c[DEPTH];

	assign ins_ok      = is_insert && !full && !any_hit;
	assign serve_ok    = is_serve && (count_q != '0);
	assign withdraw_ok = is_withdraw && any_hit;
	assign ok_d        = ins_ok || serve_ok || withdraw_ok;
	assign served_d    = serve_ok ? slot[0].id : '0;

	assign new_entry.id   = req.entry_id;
	assign new_entry.pref = ins_pref;

	assign hit_c[0]  = 1'b0;
	assign pref_c[0] = 1'b0;

	// cell row with per-slot control
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		tcpq_pkg::entry_t prev_e;
		tcpq_pkg::entry_t next_e;

		if (i == 0) begin : g_head
			assign prev_e = new_entry;
		end else begin : g_body
			assign prev_e = slot[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign next_e = new_entry;
		end else begin : g_inner
			assign next_e = slot[i+1];
		end

		assign ctrl[i].occupied       = CNT_W'(i) < count_q;
		assign ctrl[i].load           = fire && ins_ok &&
			(ins_pref ? (CNT_W'(i) == pcount_q) : (CNT_W'(i) == count_q));
		assign ctrl[i].shift_up       = fire && ins_ok && ins_pref &&
			(CNT_W'(i) > pcount_q);
		assign ctrl[i].shift_down_all = fire && serve_ok;
		assign ctrl[i].withdraw       = fire && is_withdraw;

		tcpq_cell u_cell (
			.clk          (clk),
			.ctrl         (ctrl[i]),
			.key_id       (req.entry_id),
			.new_entry    (new_entry),
			.prev_entry   (prev_e),
			.next_entry   (next_e),
			.hit_in       (hit_c[i]),
			.pref_hit_in  (pref_c[i]),
			.entry        (slot[i]),
			.hit_out      (hit_c[i+1]),
			.pref_hit_out (pref_c[i+1])
		);
	end

	// next counts
	always_comb begin
		count_d  = count_q;
		pcount_d = pcount_q;
		priority if (ins_ok) begin
			count_d = count_q + CNT_W'(1);
			if (ins_pref) begin
				pcount_d = pcount_q + CNT_W'(1);
			end
		end else if (serve_ok) begin
			count_d = count_q - CNT_W'(1);
			if (pcount_q != '0) begin
				pcount_d = pcount_q - CNT_W'(1);
			end
		end else if (withdraw_ok) begin
			count_d = count_q - CNT_W'(1);
			if (pref_c[DEPTH]) begin
				pcount_d = pcount_q - CNT_W'(1);
			end
		end else begin
			count_d  = count_q;
			pcount_d = pcount_q;
		end
	end

	// counters and threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			pcount_q <= '0;
			thr_q    <= tcpq_pkg::THRESHOLD_RESET;
		end else begin
			if (fire) begin
				count_q  <= count_d;
				pcount_q <= pcount_d;
			end
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
		end
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (fire) begin
			ok_q     <= ok_d;
			served_q <= served_d;
			occ_q    <= tcpq_pkg::OCC_W'(count_d);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.ok        = ok_q;
	assign rsp.served_id = served_q;
	assign rsp.occupancy = occ_q;

	// checks
	`TCPQ_ASSERT_ALWAYS(a_pref_within_total, pcount_q <= count_q, "preferred count exceeds total")
	`TCPQ_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH), "total count exceeds depth")
	`TCPQ_ASSERT_NEXT(a_empty_serve, fire && is_serve && (count_q == '0), !ok_q && (served_q == '0), "serve on empty queue reported success")

endmodule

// ----- tb/two_class_priority_queue_tb.sv -----
`timescale 1ns / 1ps
module two_class_priority_queue_tb;
	import tcpq_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int POOL_SIZE = 24;
	localparam int MAX_GAP   = 9;

	typedef struct packed {
		logic              ok;
		logic [ID_W-1:0]   served_id;
		logic [OCC_W-1:0]  occupancy;
	} outcome_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [LEVEL_W-1:0] cfg_wdata;

	tcpq_req_if req_ch();
	tcpq_rsp_if rsp_ch();

	two_class_priority_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// shadow copy of the queue contents and threshold
	logic [ID_W-1:0]    shadow_id [DEPTH];
	logic               shadow_pref [DEPTH];
	int                 shadow_total;
	int                 shadow_pref_count;
	logic [LEVEL_W-1:0] shadow_threshold;

	outcome_t        pending_outcomes[$];
	logic [ID_W-1:0] id_pool [POOL_SIZE];
	int              mismatch_count;
	bit              steady;
	bit              rsp_moved = 1'b0;
	int              rsp_hold = 0;

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// run limit
	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic int draw_gap();
		return steady ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// slot holding id, or shadow_total when absent
	function automatic int find_held(input logic [ID_W-1:0] id);
		for (int i = 0; i < shadow_total; i++) begin
			if (shadow_id[i] == id)
				return i;
		end
		return shadow_total;
	endfunction

	// remove one slot and close the gap behind it
	function automatic void drop_slot(input int pos);
		if (shadow_pref[pos])
			shadow_pref_count--;
		for (int i = pos; i + 1 < shadow_total; i++) begin
			shadow_id[i]   = shadow_id[i + 1];
			shadow_pref[i] = shadow_pref[i + 1];
		end
		shadow_total--;
	endfunction

	// apply one command to the shadow queue and return its outcome
	function automatic outcome_t predict_command(input logic [CMD_W-1:0] cmd,
			input logic [ID_W-1:0] id, input logic [LEVEL_W-1:0] lvl);
		outcome_t res;
		int pos;
		res = '0;
		case (cmd)
			CMD_INSERT: begin
				if (shadow_total < DEPTH && find_held(id) == shadow_total) begin
					res.ok = 1'b1;
					if (lvl >= shadow_threshold) begin
						// normal class moves up one slot
						for (int i = shadow_total; i > shadow_pref_count; i--) begin
							shadow_id[i]   = shadow_id[i - 1];
							shadow_pref[i] = shadow_pref[i - 1];
						end
						shadow_id[shadow_pref_count]   = id;
						shadow_pref[shadow_pref_count] = 1'b1;
						shadow_pref_count++;
					end else begin
						shadow_id[shadow_total]   = id;
						shadow_pref[shadow_total] = 1'b0;
					end
					shadow_total++;
				end
			end
			CMD_SERVE: begin
				if (shadow_total > 0) begin
					res.ok        = 1'b1;
					res.served_id = shadow_id[0];
					drop_slot(0);
				end
			end
			CMD_WITHDRAW: begin
				pos = find_held(id);
				if (pos < shadow_total) begin
					drop_slot(pos);
					res.ok = 1'b1;
				end
			end
			default: ;
		endcase
		res.occupancy = OCC_W'(shadow_total);
		return res;
	endfunction

	function automatic void report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch at %0t: %s", $time, what);
	endfunction

	// response checker, sampled at the falling edge ahead of the transfer
	always @(negedge clk) begin
		outcome_t want;
		rsp_moved = arst_n && rsp_ch.valid && rsp_ch.ready;
		if (rsp_moved) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch($sformatf("response with none expected: ok=%0d served_id=%h occupancy=%0d",
					rsp_ch.ok, rsp_ch.served_id, rsp_ch.occupancy));
			end else begin
				want = pending_outcomes.pop_front();
				if (rsp_ch.ok !== want.ok || rsp_ch.served_id !== want.served_id ||
						rsp_ch.occupancy !== want.occupancy)
					report_mismatch($sformatf(
						"expected ok=%0d served_id=%h occupancy=%0d, got ok=%0d served_id=%h occupancy=%0d",
						want.ok, want.served_id, want.occupancy,
						rsp_ch.ok, rsp_ch.served_id, rsp_ch.occupancy));
			end
		end
	end

	// response side stalls a random number of cycles after each transaction, except in steady mode
	always @(posedge clk) begin
		if (rsp_moved)
			rsp_hold = draw_gap();
		if (rsp_hold > 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_hold--;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// one request transaction, returns at the accepting edge
	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
			input logic [LEVEL_W-1:0] lvl);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.command  <= cmd;
		req_ch.entry_id <= id;
		req_ch.level    <= lvl;
		do @(negedge clk); while (!req_ch.ready);
		@(posedge clk);
		pending_outcomes.push_back(predict_command(cmd, id, lvl));
	endtask

	// hold off requests until every response is back
	task automatic wait_until_drained();
		req_ch.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [LEVEL_W-1:0] value);
		wait_until_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we           <= 1'b0;
		shadow_threshold = value;
	endtask

	// random command, mostly on ids from a small pool so hits are common
	task automatic random_command(input int insert_weight);
		int pick;
		logic [CMD_W-1:0]   cmd;
		logic [ID_W-1:0]    id;
		logic [LEVEL_W-1:0] lvl;
		pick = $urandom_range(0, 99);
		if (pick < insert_weight)
			cmd = CMD_INSERT;
		else if (pick >= 96)
			cmd = CMD_UNUSED;
		else if (pick[0])
			cmd = CMD_SERVE;
		else
			cmd = CMD_WITHDRAW;
		if (cmd == CMD_WITHDRAW && shadow_total > 0 && $urandom_range(0, 9) < 7)
			id = shadow_id[$urandom_range(0, shadow_total - 1)];
		else if ($urandom_range(0, 9) < 8)
			id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			id = ID_W'($urandom);
		// levels cluster around the threshold edge
		case ($urandom_range(0, 4))
			2: lvl = shadow_threshold - 8'd1;
			3: lvl = shadow_threshold;
			4: lvl = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: lvl = LEVEL_W'($urandom);
		endcase
		send_command(cmd, id, lvl);
	endtask

	// occupancy walks up and down as the insert share changes
	task automatic random_phase(input int count);
		int weight;
		weight = 50;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: weight = 25;
					1: weight = 50;
					default: weight = 75;
				endcase
			end
			random_command(weight);
		end
	endtask

	// corner cases at the reset threshold
	task automatic test_directed();
		send_command(CMD_SERVE, 16'h1234, 8'h00);
		send_command(CMD_WITHDRAW, 16'h0000, 8'h00);
		send_command(CMD_INSERT, 16'h0000, 8'd0);
		send_command(CMD_INSERT, 16'hFFFF, 8'd255);
		send_command(CMD_INSERT, 16'h00A5, 8'd60);
		send_command(CMD_INSERT, 16'h5A00, 8'd59);
		send_command(CMD_INSERT, 16'hFFFF, 8'd0);
		send_command(CMD_UNUSED, 16'h0000, 8'hFF);
		send_command(CMD_WITHDRAW, 16'h00A5, 8'h00);
		send_command(CMD_WITHDRAW, 16'h7777, 8'h00);
		send_command(CMD_SERVE, 16'h0000, 8'h00);
		// fill up with alternating classes, then push past full
		for (int i = 0; i < DEPTH - 2; i++)
			send_command(CMD_INSERT, ID_W'(16'h0100 + i), i[0] ? 8'd200 : 8'd10);
		send_command(CMD_INSERT, 16'hBEEF, 8'd255);
		send_command(CMD_WITHDRAW, 16'h5A00, 8'h00);
		send_command(CMD_SERVE, 16'hFFFF, 8'h00);
	endtask

	// random traffic across a range of thresholds, extremes included
	task automatic test_threshold_sweep();
		logic [LEVEL_W-1:0] sweep [6];
		sweep = '{8'd0, 8'd255, 8'd1, 8'd254, LEVEL_W'($urandom), THRESHOLD_RESET};
		foreach (sweep[k]) begin
			write_threshold(sweep[k]);
			random_phase(200);
		end
	endtask

	// back to back transactions with both sides always ready
	task automatic test_steady_stream();
		write_threshold(8'd128);
		steady = 1'b1;
		random_phase(200);
		wait_until_drained();
		steady = 1'b0;
	endtask

	initial begin
		req_ch.valid    = 1'b0;
		req_ch.command  = CMD_INSERT;
		req_ch.entry_id = '0;
		req_ch.level    = '0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		arst_n          = 1'b0;
		steady          = 1'b0;
		mismatch_count  = 0;
		shadow_total      = 0;
		shadow_pref_count = 0;
		shadow_threshold  = THRESHOLD_RESET;
		foreach (id_pool[i])
			id_pool[i] = ID_W'($urandom);
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hFFFF;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_threshold_sweep();
		test_steady_stream();

		wait_until_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/tcpq_pkg.sv
rtl/tcpq_req_if.sv
rtl/tcpq_rsp_if.sv
rtl/tcpq_cell.sv
rtl/two_class_priority_queue.sv
tb/two_class_priority_queue_tb.sv
